// ===== sv/i2c_master_bit_engine_assert.svh =====
// Assertion macros for the I2C master bit engine.
// Each macro expects a clock named clk and a synchronous reset named rst.
`ifndef I2C_MASTER_BIT_ENGINE_ASSERT_SVH
`define I2C_MASTER_BIT_ENGINE_ASSERT_SVH

// Check a condition at every clock edge outside reset.
`define I2CMBE_ASSERT_NOW(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check a consequence in the cycle after its trigger.
`define I2CMBE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== sv/i2cmbe_pkg.sv =====
// Shared types and constants for the I2C master bit engine.
// No dependencies.
`default_nettype none

package i2cmbe_pkg;

  typedef enum logic [2:0] {
    OP_START = 3'd0,
    OP_STOP  = 3'd1,
    OP_WRITE = 3'd2,
    OP_WAIT  = 3'd3,
    OP_READ  = 3'd4
  } opcode_t;

  localparam int unsigned REG_W     = 16;
  localparam logic [REG_W-1:0] HALF_PERIOD_RESET = 16'd100;
  localparam logic [REG_W-1:0] ACK_TIMEOUT_RESET = 16'd2000;
  localparam logic [3:0] BITS_PER_BYTE = 4'd8;

  typedef enum logic {
    REG_HALF_PERIOD = 1'b0,
    REG_ACK_TIMEOUT = 1'b1
  } reg_index_t;

endpackage

`default_nettype wire

// ===== sv/i2c_master_bit_engine.sv =====
// I2C master bit engine: byte-level command sequencer, one tick per input item.
// Depends on i2cmbe_pkg and i2c_master_bit_engine_assert.svh.
// Results are registered: an accepted item gives its result item in the next cycle.
// Throughput: one item per cycle; the only limit is the single output
//   register, so input is stalled only while a result waits to be taken.
// Reset: synchronous, active high; engine idle, SCL and SDA driven high,
//   half period 100 ticks, ack timeout 2000 ticks, no result pending.
`default_nettype none

`include "i2c_master_bit_engine_assert.svh"

module i2c_master_bit_engine (
  input  logic        clk,
  input  logic        rst,
  // tick input channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        cmd_valid,
  input  logic [2:0]  opcode,
  input  logic [7:0]  tx_byte,
  input  logic        ack_after_read,
  input  logic        sda_in,
  // result channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic        scl_level,
  output logic        sda_level,
  output logic        sda_drive_enable,
  output logic        busy_res,
  output logic        done_res,
  output logic [7:0]  rx_byte,
  output logic        ack_error,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  import i2cmbe_pkg::*;

  typedef enum logic [3:0] {
    PH_IDLE = 4'd0,
    PH_ST_A = 4'd1,
    PH_ST_B = 4'd2,
    PH_SP_A = 4'd3,
    PH_SP_B = 4'd4,
    PH_WR_H = 4'd5,
    PH_WR_L = 4'd6,
    PH_WA_A = 4'd7,
    PH_WA_B = 4'd8,
    PH_WA_P = 4'd9,
    PH_RD_L = 4'd10,
    PH_RD_H = 4'd11,
    PH_AK_A = 4'd12,
    PH_AK_B = 4'd13
  } phase_t;

  // ---------------------------------------------------------------------
  // Configuration registers. Written between items, also in the middle of
  // a command; the new value applies from the next tick on.
  // ---------------------------------------------------------------------
  logic [REG_W-1:0] half_period;
  logic [REG_W-1:0] ack_timeout;
  reg_index_t       reg_sel;
  logic             cfg_write;

  assign pready    = 1'b1;
  assign reg_sel   = reg_index_t'(paddr[2]);
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      half_period <= HALF_PERIOD_RESET;
      ack_timeout <= ACK_TIMEOUT_RESET;
    end else if (cfg_write) begin
      case (reg_sel)
        REG_HALF_PERIOD: half_period <= pwdata[REG_W-1:0];
        REG_ACK_TIMEOUT: ack_timeout <= pwdata[REG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_HALF_PERIOD: prdata = {{(32-REG_W){1'b0}}, half_period};
      REG_ACK_TIMEOUT: prdata = {{(32-REG_W){1'b0}}, ack_timeout};
      default:         prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------
  // Engine state. The output fields are the state itself, so they hold
  // while a result is stalled because no tick is accepted meanwhile.
  // ---------------------------------------------------------------------
  phase_t           phase, phase_next;
  logic [3:0]       bit_count, bit_count_next;
  logic [REG_W-1:0] tick_count, tick_count_next;
  logic [7:0]       shift_reg, shift_reg_next;
  logic [REG_W-1:0] wait_count, wait_count_next;
  logic             scl_reg, scl_reg_next;
  logic             sda_reg, sda_reg_next;
  logic             sda_oe_reg, sda_oe_reg_next;
  logic             ack_select, ack_select_next;
  logic             error_flag, error_flag_next;
  logic [7:0]       rx_hold, rx_hold_next;
  logic             done_reg, done_next;
  logic             result_valid;

  logic             tick;
  logic [REG_W:0]   tick_inc;
  logic             delay_over;
  logic [REG_W-1:0] tick_after;
  logic [REG_W:0]   wait_inc;
  logic [3:0]       bit_inc;

  // One output register: take a new tick unless a result waits and is not taken.
  assign in_ready = !result_valid || out_ready;
  assign tick     = in_valid && in_ready;

  // Half-period timer: a zero setting ends the delay on its first tick.
  assign tick_inc   = {1'b0, tick_count} + 1'b1;
  assign delay_over = tick_inc >= {1'b0, half_period};
  assign tick_after = delay_over ? '0 : tick_inc[REG_W-1:0];
  assign wait_inc   = {1'b0, wait_count} + 1'b1;
  assign bit_inc    = bit_count + 1'b1;

  always_comb begin
    phase_next      = phase;
    bit_count_next  = bit_count;
    tick_count_next = tick_count;
    shift_reg_next  = shift_reg;
    wait_count_next = wait_count;
    scl_reg_next    = scl_reg;
    sda_reg_next    = sda_reg;
    sda_oe_reg_next = sda_oe_reg;
    ack_select_next = ack_select;
    error_flag_next = error_flag;
    rx_hold_next    = rx_hold;
    done_next       = 1'b0;

    case (phase)
      PH_IDLE: begin
        // Accept a command only with a known opcode; others leave us idle.
        if (cmd_valid && (opcode <= OP_READ)) begin
          tick_count_next = '0;
          error_flag_next = 1'b0;
          case (opcode_t'(opcode))
            OP_START: begin
              sda_oe_reg_next = 1'b1;
              sda_reg_next    = 1'b1;
              scl_reg_next    = 1'b1;
              phase_next      = PH_ST_A;
            end
            OP_STOP: begin
              sda_oe_reg_next = 1'b1;
              sda_reg_next    = 1'b0;
              scl_reg_next    = 1'b1;
              phase_next      = PH_SP_A;
            end
            OP_WRITE: begin
              // Drive the MSB right away with SCL high.
              sda_oe_reg_next = 1'b1;
              bit_count_next  = '0;
              sda_reg_next    = tx_byte[7];
              shift_reg_next  = {tx_byte[6:0], 1'b0};
              scl_reg_next    = 1'b1;
              phase_next      = PH_WR_H;
            end
            OP_WAIT: begin
              sda_oe_reg_next = 1'b0;
              sda_reg_next    = 1'b1;
              wait_count_next = '0;
              phase_next      = PH_WA_A;
            end
            default: begin
              sda_oe_reg_next = 1'b0;
              bit_count_next  = '0;
              shift_reg_next  = '0;
              ack_select_next = ack_after_read;
              scl_reg_next    = 1'b0;
              phase_next      = PH_RD_L;
            end
          endcase
        end
      end
      PH_ST_A: begin
        tick_count_next = tick_after;
        if (delay_over) begin
          sda_reg_next = 1'b0;
          phase_next   = PH_ST_B;
        end
      end
      PH_ST_B, PH_SP_B, PH_AK_B: begin
        tick_count_next = tick_after;
        if (delay_over) begin
          scl_reg_next = 1'b0;
          phase_next   = PH_IDLE;
          done_next    = 1'b1;
        end
      end
      PH_SP_A: begin
        tick_count_next = tick_after;
        if (delay_over) begin
          sda_reg_next = 1'b1;
          phase_next   = PH_SP_B;
        end
      end
      PH_WR_H: begin
        tick_count_next = tick_after;
        if (delay_over) begin
          scl_reg_next = 1'b0;
          phase_next   = PH_WR_L;
        end
      end
      PH_WR_L: begin
        tick_count_next = tick_after;
        if (delay_over) begin
          bit_count_next = bit_inc;
          if (bit_inc >= BITS_PER_BYTE) begin
            phase_next = PH_IDLE;
            done_next  = 1'b1;
          end else begin
            sda_reg_next   = shift_reg[7];
            shift_reg_next = {shift_reg[6:0], 1'b0};
            scl_reg_next   = 1'b1;
            phase_next     = PH_WR_H;
          end
        end
      end
      PH_WA_A, PH_AK_A: begin
        tick_count_next = tick_after;
        if (delay_over) begin
          scl_reg_next = 1'b1;
          phase_next   = (phase == PH_WA_A) ? PH_WA_B : PH_AK_B;
        end
      end
      PH_WA_B: begin
        tick_count_next = tick_after;
        if (delay_over) phase_next = PH_WA_P;
      end
      PH_WA_P: begin
        // Poll SDA with SCL high; on timeout flag the error and stop.
        if (!sda_in) begin
          scl_reg_next = 1'b0;
          phase_next   = PH_IDLE;
          done_next    = 1'b1;
        end else if (wait_inc > {1'b0, ack_timeout}) begin
          wait_count_next = '0;
          error_flag_next = 1'b1;
          sda_oe_reg_next = 1'b1;
          sda_reg_next    = 1'b0;
          scl_reg_next    = 1'b1;
          tick_count_next = '0;
          phase_next      = PH_SP_A;
        end else begin
          wait_count_next = wait_inc[REG_W-1:0];
        end
      end
      PH_RD_L: begin
        tick_count_next = tick_after;
        if (delay_over) begin
          // Sample SDA on the tick SCL goes high.
          scl_reg_next   = 1'b1;
          shift_reg_next = {shift_reg[6:0], sda_in};
          phase_next     = PH_RD_H;
        end
      end
      PH_RD_H: begin
        tick_count_next = tick_after;
        if (delay_over) begin
          bit_count_next = bit_inc;
          scl_reg_next   = 1'b0;
          if (bit_inc >= BITS_PER_BYTE) begin
            rx_hold_next    = shift_reg;
            sda_oe_reg_next = 1'b1;
            sda_reg_next    = !ack_select;
            phase_next      = PH_AK_A;
          end else begin
            phase_next = PH_RD_L;
          end
        end
      end
      default: phase_next = PH_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_IDLE;
      bit_count    <= '0;
      tick_count   <= '0;
      shift_reg    <= '0;
      wait_count   <= '0;
      scl_reg      <= 1'b1;
      sda_reg      <= 1'b1;
      sda_oe_reg   <= 1'b1;
      ack_select   <= 1'b0;
      error_flag   <= 1'b0;
      rx_hold      <= '0;
      done_reg     <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      // Advance the engine only on an accepted tick.
      if (tick) begin
        phase      <= phase_next;
        bit_count  <= bit_count_next;
        tick_count <= tick_count_next;
        shift_reg  <= shift_reg_next;
        wait_count <= wait_count_next;
        scl_reg    <= scl_reg_next;
        sda_reg    <= sda_reg_next;
        sda_oe_reg <= sda_oe_reg_next;
        ack_select <= ack_select_next;
        error_flag <= error_flag_next;
        rx_hold    <= rx_hold_next;
        done_reg   <= done_next;
      end
      // Hold the result until taken; each tick loads a fresh one.
      if (tick) begin
        result_valid <= 1'b1;
      end else if (out_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  assign out_valid        = result_valid;
  assign scl_level        = scl_reg;
  assign sda_level        = sda_reg;
  assign sda_drive_enable = sda_oe_reg;
  assign busy_res         = (phase != PH_IDLE);
  assign done_res         = done_reg;
  assign rx_byte          = rx_hold;
  assign ack_error        = error_flag;

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  `I2CMBE_ASSERT_NOW(a_done_idle, !done_reg || (phase == PH_IDLE),
    "done pulse while engine still busy")
  `I2CMBE_ASSERT_NOW(a_bit_count_range, bit_count <= BITS_PER_BYTE,
    "bit counter ran past one byte")
  `I2CMBE_ASSERT_NEXT(a_error_stops, tick && !error_flag && error_flag_next,
    phase == PH_SP_A && sda_oe_reg && !sda_reg && scl_reg,
    "ack timeout did not start a stop")
  `I2CMBE_ASSERT_NEXT(a_stall_holds, result_valid && !out_ready,
    $stable(phase) && $stable(tick_count) && $stable(done_reg),
    "engine advanced while a result was stalled")
  `I2CMBE_ASSERT_NEXT(a_done_scl_low, tick && done_next,
    !scl_reg && (phase == PH_IDLE),
    "command finished without releasing SCL low")

endmodule

`default_nettype wire
